FILE: hdl/psrt_pkg.sv
`default_nettype none
package psrt_pkg;

    localparam int COORD_WIDTH        = 16;
    localparam int TRIG_FRAC_BITS     = 14;
    localparam int SCALE_FRAC_BITS    = 8;
    localparam int ANGLE_STEP_DEGREES = 5;
    localparam int FULL_TURN          = 360;
    localparam int STEP_COUNT         = FULL_TURN / ANGLE_STEP_DEGREES;
    localparam int QUARTER_STEPS      = STEP_COUNT / 4;
    localparam int QW                 = $clog2(QUARTER_STEPS + 1);

    localparam int LANE_BITS = 16;
    localparam int IDX_W     = 7;
    localparam int MODE_W    = 3;
    localparam int ANGLE_W   = 3 * IDX_W;
    localparam int REG_W     = 3 * LANE_BITS;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int SPW   = COORD_WIDTH + LANE_BITS;
    localparam int M1W   = TW + DW;
    localparam int R1W   = TRIG_FRAC_BITS + COORD_WIDTH + 2;
    localparam int M2W   = TW + R1W;
    localparam int S2W   = M2W + 1;
    localparam int X2W   = R1W + 1;
    localparam int M3W   = TW + X2W;
    localparam int S3W   = M3W + 1;
    localparam int SAT_W = 64;

    localparam int PIPE_LATENCY = 11;

    localparam int MODE_SCALE = 0;
    localparam int MODE_ROT   = 1;
    localparam int MODE_TRANS = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd4;

    localparam logic [REG_W-1:0] SCALE_RESET = 48'h0100_0100_0100;

    localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // sin 0..90 deg, Q1.14
    localparam int QUARTER_SINE [QUARTER_STEPS + 1] = '{
        0, 1428, 2845, 4240, 5604, 6924, 8192, 9397, 10531, 11585,
        12551, 13421, 14189, 14849, 15396, 15825, 16135, 16322, 16384
    };

    typedef struct packed {
        logic signed [TW-1:0] sx;
        logic signed [TW-1:0] cx;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sz;
        logic signed [TW-1:0] cz;
    } t_trig;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  scale;
        logic [REG_W-1:0]  center;
        logic [REG_W-1:0]  offset;
        t_trig             trig;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_xyz;

    typedef struct packed {
        logic valid;
        t_xyz c;
    } t_point;

    function automatic logic signed [LANE_BITS-1:0] lane(input logic [REG_W-1:0] r,
                                                          input logic [1:0] k);
        return r[k*LANE_BITS +: LANE_BITS];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] saturate(
        input logic signed [SAT_W-1:0] v);
        logic signed [COORD_WIDTH-1:0] res;
        if (v > COORD_MAX) begin
            res = COORD_WIDTH'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            res = COORD_WIDTH'(COORD_MIN);
        end else begin
            res = v[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] i);
        return (i >= IDX_W'(STEP_COUNT)) ? i - IDX_W'(STEP_COUNT) : i;
    endfunction

    function automatic logic [IDX_W-1:0] cos_index(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] j;
        j = {1'b0, i} + (IDX_W + 1)'(QUARTER_STEPS);
        if (j >= (IDX_W + 1)'(STEP_COUNT)) begin
            j = j - (IDX_W + 1)'(STEP_COUNT);
        end
        return j[IDX_W-1:0];
    endfunction

    function automatic logic signed [TW-1:0] sine_at(input logic [IDX_W-1:0] i);
        logic [1:0]           q;
        logic [IDX_W-1:0]     r;
        logic signed [TW-1:0] m;
        if (i >= IDX_W'(3 * QUARTER_STEPS)) begin
            q = 2'd3;
            r = i - IDX_W'(3 * QUARTER_STEPS);
        end else if (i >= IDX_W'(2 * QUARTER_STEPS)) begin
            q = 2'd2;
            r = i - IDX_W'(2 * QUARTER_STEPS);
        end else if (i >= IDX_W'(QUARTER_STEPS)) begin
            q = 2'd1;
            r = i - IDX_W'(QUARTER_STEPS);
        end else begin
            q = 2'd0;
            r = i;
        end
        if (q[0]) begin
            m = TW'(QUARTER_SINE[QW'(QUARTER_STEPS) - r[QW-1:0]]);
        end else begin
            m = TW'(QUARTER_SINE[r[QW-1:0]]);
        end
        return q[1] ? -m : m;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/psrt_cfg.sv
`default_nettype none
module psrt_cfg import psrt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [MODE_W-1:0]  r_mode;
    logic [ANGLE_W-1:0] r_angle;
    logic [REG_W-1:0]   r_scale;
    logic [REG_W-1:0]   r_center;
    logic [REG_W-1:0]   r_offset;
    t_trig              r_trig;
    t_trig              n_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_angle  <= '0;
            r_scale  <= SCALE_RESET;
            r_center <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_ANGLE:  r_angle  <= i_cfg_data[ANGLE_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [IDX_W-1:0] ix, iy, iz;
        ix = wrap_index(r_angle[0*IDX_W +: IDX_W]);
        iy = wrap_index(r_angle[1*IDX_W +: IDX_W]);
        iz = wrap_index(r_angle[2*IDX_W +: IDX_W]);
        n_trig.sx = sine_at(ix);
        n_trig.cx = sine_at(cos_index(ix));
        n_trig.sy = sine_at(iy);
        n_trig.cy = sine_at(cos_index(iy));
        n_trig.sz = sine_at(iz);
        n_trig.cz = sine_at(cos_index(iz));
    end

    // trig lookup registered; the user must see that angles only change while idle, which the block leaves unchecked
    always_ff @(posedge i_clk) begin
        r_trig <= n_trig;
    end

    always_comb begin
        o_cfg.mode   = r_mode;
        o_cfg.scale  = r_scale;
        o_cfg.center = r_center;
        o_cfg.offset = r_offset;
        o_cfg.trig   = r_trig;
    end

endmodule
`default_nettype wire

FILE: hdl/psrt_scale.sv
`default_nettype none
module psrt_scale import psrt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_point i_pt,
    output t_point      o_pt
);

    localparam logic signed [SPW-1:0] BIAS = SPW'((longint'(1) << SCALE_FRAC_BITS) - 1);

    logic                  r1_valid;
    t_xyz                  r1_p;
    logic signed [SPW-1:0] r1_mx, r1_my, r1_mz;
    t_point                r2_pt;
    t_xyz                  n_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_pt.valid <= 1'b0;
        end else begin
            r1_valid    <= i_pt.valid;
            r2_pt.valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p  <= i_pt.c;
        r1_mx <= i_pt.c.x * lane(i_cfg.scale, 2'd0);
        r1_my <= i_pt.c.y * lane(i_cfg.scale, 2'd1);
        r1_mz <= i_pt.c.z * lane(i_cfg.scale, 2'd2);
        r2_pt.c <= n_s;
    end

    // divide by 2^frac, toward zero, then clamp; pass the point through when scale mode is off
    always_comb begin
        logic signed [SPW-1:0] bx, by, bz, tx, ty, tz;
        bx = r1_mx[SPW-1] ? BIAS : SPW'(0);
        by = r1_my[SPW-1] ? BIAS : SPW'(0);
        bz = r1_mz[SPW-1] ? BIAS : SPW'(0);
        tx = (r1_mx + bx) >>> SCALE_FRAC_BITS;
        ty = (r1_my + by) >>> SCALE_FRAC_BITS;
        tz = (r1_mz + bz) >>> SCALE_FRAC_BITS;
        if (i_cfg.mode[MODE_SCALE]) begin
            n_s.x = saturate(SAT_W'(tx));
            n_s.y = saturate(SAT_W'(ty));
            n_s.z = saturate(SAT_W'(tz));
        end else begin
            n_s = r1_p;
        end
    end

    assign o_pt = r2_pt;

endmodule
`default_nettype wire

FILE: hdl/psrt_rotate.sv
`default_nettype none
module psrt_rotate import psrt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_point i_pt,
    output t_point      o_pt
);

    localparam logic signed [S2W-1:0] BIAS2 = S2W'((longint'(1) << TRIG_FRAC_BITS) - 1);
    localparam logic signed [S3W-1:0] BIAS3 =
        S3W'((longint'(1) << (2 * TRIG_FRAC_BITS)) - 1);
    localparam logic signed [X2W-1:0] BIASZ = X2W'((longint'(1) << TRIG_FRAC_BITS) - 1);

    logic signed [LANE_BITS-1:0] w_c0, w_c1, w_c2;

    logic [6:0] r_valid;

    t_xyz r3_p, r4_p, r5_p, r6_p, r7_p, r8_p, r9_p;

    logic signed [DW-1:0]  r3_dx, r3_dy, r3_dz;
    logic signed [DW-1:0]  r4_x0;
    logic signed [M1W-1:0] r4_cxy, r4_sxz, r4_sxy, r4_cxz;
    logic signed [DW-1:0]  r5_x0;
    logic signed [R1W-1:0] r5_y1, r5_z1;
    logic signed [M1W-1:0] r6_cyx, r6_syx;
    logic signed [M2W-1:0] r6_syz, r6_cyz;
    logic signed [R1W-1:0] r6_y2;
    logic signed [X2W-1:0] r7_x2, r7_z2;
    logic signed [R1W-1:0] r7_y2;
    logic signed [M3W-1:0] r8_czx, r8_szy, r8_szx, r8_czy;
    logic signed [X2W-1:0] r8_z2;
    logic signed [S3W-1:0] r9_sx, r9_sy;
    logic signed [X2W-1:0] r9_z2;
    t_point                r10_pt;

    logic signed [S2W-1:0] n_tx, n_tz;
    t_xyz                  n_r;

    assign w_c0 = lane(i_cfg.center, 2'd0);
    assign w_c1 = lane(i_cfg.center, 2'd1);
    assign w_c2 = lane(i_cfg.center, 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r10_pt.valid <= 1'b0;
        end else begin
            r_valid      <= {r_valid[5:0], i_pt.valid};
            r10_pt.valid <= r_valid[6];
        end
    end

    always_ff @(posedge i_clk) begin
        // offset from center
        r3_p  <= i_pt.c;
        r3_dx <= DW'(i_pt.c.x) - DW'(w_c0);
        r3_dy <= DW'(i_pt.c.y) - DW'(w_c1);
        r3_dz <= DW'(i_pt.c.z) - DW'(w_c2);
        // X turn products
        r4_p   <= r3_p;
        r4_x0  <= r3_dx;
        r4_cxy <= i_cfg.trig.cx * r3_dy;
        r4_sxz <= i_cfg.trig.sx * r3_dz;
        r4_sxy <= i_cfg.trig.sx * r3_dy;
        r4_cxz <= i_cfg.trig.cx * r3_dz;
        // X turn sums, Q14
        r5_p  <= r4_p;
        r5_x0 <= r4_x0;
        r5_y1 <= R1W'(r4_cxy + r4_sxz);
        r5_z1 <= R1W'(r4_cxz - r4_sxy);
        // Y turn products; x1 = x0 << 14 folded in later
        r6_p   <= r5_p;
        r6_y2  <= r5_y1;
        r6_cyx <= i_cfg.trig.cy * r5_x0;
        r6_syz <= i_cfg.trig.sy * r5_z1;
        r6_syx <= i_cfg.trig.sy * r5_x0;
        r6_cyz <= i_cfg.trig.cy * r5_z1;
        // Y turn sums back to Q14
        r7_p  <= r6_p;
        r7_y2 <= r6_y2;
        r7_x2 <= X2W'(n_tx);
        r7_z2 <= X2W'(n_tz);
        // Z turn products
        r8_p   <= r7_p;
        r8_z2  <= r7_z2;
        r8_czx <= i_cfg.trig.cz * r7_x2;
        r8_szy <= i_cfg.trig.sz * r7_y2;
        r8_szx <= i_cfg.trig.sz * r7_x2;
        r8_czy <= i_cfg.trig.cz * r7_y2;
        // Z turn sums, Q28
        r9_p  <= r8_p;
        r9_z2 <= r8_z2;
        r9_sx <= S3W'(r8_czx) + S3W'(r8_szy);
        r9_sy <= S3W'(r8_czy) - S3W'(r8_szx);
        // back to integer, restore center, clamp; pass the point through when rotate mode is off
        r10_pt.c <= n_r;
    end

    always_comb begin
        logic signed [S2W-1:0] nx, nz, bx, bz;
        nx = (S2W'(r6_cyx) <<< TRIG_FRAC_BITS) - S2W'(r6_syz);
        nz = (S2W'(r6_syx) <<< TRIG_FRAC_BITS) + S2W'(r6_cyz);
        bx = nx[S2W-1] ? BIAS2 : S2W'(0);
        bz = nz[S2W-1] ? BIAS2 : S2W'(0);
        n_tx = (nx + bx) >>> TRIG_FRAC_BITS;
        n_tz = (nz + bz) >>> TRIG_FRAC_BITS;
    end

    always_comb begin
        logic signed [S3W-1:0] bx, by, tx, ty;
        logic signed [X2W-1:0] bz, tz;
        bx = r9_sx[S3W-1] ? BIAS3 : S3W'(0);
        by = r9_sy[S3W-1] ? BIAS3 : S3W'(0);
        bz = r9_z2[X2W-1] ? BIASZ : X2W'(0);
        tx = (r9_sx + bx) >>> (2 * TRIG_FRAC_BITS);
        ty = (r9_sy + by) >>> (2 * TRIG_FRAC_BITS);
        tz = (r9_z2 + bz) >>> TRIG_FRAC_BITS;
        if (i_cfg.mode[MODE_ROT]) begin
            n_r.x = saturate(SAT_W'(tx) + SAT_W'(w_c0));
            n_r.y = saturate(SAT_W'(ty) + SAT_W'(w_c1));
            n_r.z = saturate(SAT_W'(tz) + SAT_W'(w_c2));
        end else begin
            n_r = r9_p;
        end
    end

    assign o_pt = r10_pt;

endmodule
`default_nettype wire

FILE: hdl/psrt_translate.sv
`default_nettype none
module psrt_translate import psrt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_point i_pt,
    output t_point      o_pt
);

    t_point r_out;
    t_xyz   n_c;

    always_comb begin
        if (i_cfg.mode[MODE_TRANS]) begin
            n_c.x = saturate(SAT_W'(i_pt.c.x) + SAT_W'(lane(i_cfg.offset, 2'd0)));
            n_c.y = saturate(SAT_W'(i_pt.c.y) + SAT_W'(lane(i_cfg.offset, 2'd1)));
            n_c.z = saturate(SAT_W'(i_pt.c.z) + SAT_W'(lane(i_cfg.offset, 2'd2)));
        end else begin
            n_c = i_pt.c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.c <= n_c;
    end

    assign o_pt = r_out;

`ifndef NO_ASSERTIONS
    a_pass_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && !i_cfg.mode[MODE_TRANS]) |=> (r_out.c == $past(i_pt.c)))
        else $error("translate bypass altered the point");
`endif

endmodule
`default_nettype wire

FILE: hdl/point_scale_rotate_translate_3d.sv
`default_nettype none
// An accepted request raises o_strobe with its result at the end of the pipeline,
// and the receiver takes the result while o_strobe is high.
// Throughput: one request per cycle, fully pipelined (2 scale, 8 rotate, 1 translate stages).
// busy stays low; the receiver cannot stall, so the pipeline never holds.
// Reset: synchronous active-low i_rst_n clears all stage valid bits and loads register defaults.
// Config writes take effect for requests issued after the write has settled.
module point_scale_rotate_translate_3d import psrt_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_z,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [REG_W-1:0]              i_cfg_data,
    output logic                               o_strobe,
    output logic signed [COORD_WIDTH-1:0]      o_result_x,
    output logic signed [COORD_WIDTH-1:0]      o_result_y,
    output logic signed [COORD_WIDTH-1:0]      o_result_z
);

    t_cfg   w_cfg;
    t_point w_in;
    t_point w_scaled;
    t_point w_rotated;
    t_point w_out;

    assign busy = 1'b0;

    always_comb begin
        w_in.valid = start && !busy;
        w_in.c.x   = i_point_x;
        w_in.c.y   = i_point_y;
        w_in.c.z   = i_point_z;
    end

    psrt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    psrt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pt    (w_in),
        .o_pt    (w_scaled)
    );

    psrt_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pt    (w_scaled),
        .o_pt    (w_rotated)
    );

    psrt_translate u_translate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pt    (w_rotated),
        .o_pt    (w_out)
    );

    assign o_strobe   = w_out.valid;
    assign o_result_x = w_out.c.x;
    assign o_result_y = w_out.c.y;
    assign o_result_z = w_out.c.z;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY o_strobe)
        else $error("request did not produce a result on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, PIPE_LATENCY))
        else $error("result strobe without a matching request");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_strobe)
        else $error("result strobe right after reset");
`endif

endmodule
`default_nettype wire
